// ===== rtl/cwm_pkg.sv =====
// ============================================================================
// cwm_pkg: shared definitions for the clipped window mean block
// Grid geometry, field widths and configuration register indexes.
// ============================================================================
package cwm_pkg;

   localparam int MAX_ROWS   = 64;
   localparam int MAX_COLS   = 64;
   localparam int GRID_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W     = $clog2(GRID_DEPTH);

   localparam int POS_W      = 6;
   localparam int CENTER_W   = 8;
   localparam int VALUE_W    = 24;
   localparam int SUM_W      = 32;
   localparam int CNT_W      = 8;
   localparam int SIZE_W     = 7;
   localparam int HALF_W     = 3;
   localparam int BND_W      = 10;
   localparam int DIV_STEP_W = $clog2(SUM_W);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_IN_USE = 2'd0,
      CSR_COLS_IN_USE = 2'd1,
      CSR_HALF_ROWS   = 2'd2,
      CSR_HALF_COLS   = 2'd3
   } csr_index_type;

   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_QUERY = 1'b1
   } req_kind_type;

endpackage

// ===== rtl/cwm_ifs.sv =====
// ============================================================================
// cwm_ifs: request and response channels of the clipped window mean block
// Valid/ready channels; a word moves when valid and ready are both high.
// ============================================================================
interface cwm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 req_type;
   logic        [cwm_pkg::POS_W-1:0]     cell_row;
   logic        [cwm_pkg::POS_W-1:0]     cell_col;
   logic signed [cwm_pkg::VALUE_W-1:0]   cell_value;
   logic signed [cwm_pkg::CENTER_W-1:0]  center_row;
   logic signed [cwm_pkg::CENTER_W-1:0]  center_col;

   modport source (
      output valid, req_type, cell_row, cell_col, cell_value, center_row, center_col,
      input  ready
   );
   modport sink (
      input  valid, req_type, cell_row, cell_col, cell_value, center_row, center_col,
      output ready
   );
endinterface

interface cwm_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [cwm_pkg::VALUE_W-1:0]   mean_value;
   logic        [cwm_pkg::CNT_W-1:0]     cells_counted;
   logic                                 window_empty;

   modport source (
      output valid, mean_value, cells_counted, window_empty,
      input  ready
   );
   modport sink (
      input  valid, mean_value, cells_counted, window_empty,
      output ready
   );
endinterface

// ===== rtl/cwm_div.sv =====
// ============================================================================
// cwm_div: bit-serial signed by unsigned divider
// Restoring division, one quotient bit per cycle, truncated toward zero.
// ============================================================================
module cwm_div (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [cwm_pkg::SUM_W-1:0]   dividend,
   input  logic        [cwm_pkg::CNT_W-1:0]   divisor,
   output logic                               done,
   output logic signed [cwm_pkg::VALUE_W-1:0] quotient
);

   logic                            busy_ff;
   logic [cwm_pkg::DIV_STEP_W-1:0]  step_ff;
   logic [cwm_pkg::SUM_W-1:0]       shift_ff;
   logic [cwm_pkg::CNT_W-1:0]       rem_ff;
   logic [cwm_pkg::CNT_W-1:0]       div_ff;
   logic                            neg_ff;
   logic                            done_ff;
   logic [cwm_pkg::VALUE_W-1:0]     quot_ff;

   logic [cwm_pkg::CNT_W:0]         trial;
   logic                            fits;
   logic [cwm_pkg::CNT_W-1:0]       rem_in;
   logic [cwm_pkg::SUM_W-1:0]       shift_in;
   logic [cwm_pkg::SUM_W-1:0]       signed_q;

   always_comb begin
      trial    = {rem_ff, shift_ff[cwm_pkg::SUM_W-1]};
      fits     = (trial >= {1'b0, div_ff});
      rem_in   = fits ? cwm_pkg::CNT_W'(trial - {1'b0, div_ff})
                      : cwm_pkg::CNT_W'(trial);
      shift_in = {shift_ff[cwm_pkg::SUM_W-2:0], fits};
      signed_q = neg_ff ? (~shift_in + 1'b1) : shift_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && !start
                    && (step_ff == cwm_pkg::DIV_STEP_W'(cwm_pkg::SUM_W - 1));
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == cwm_pkg::DIV_STEP_W'(cwm_pkg::SUM_W - 1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff   <= dividend[cwm_pkg::SUM_W-1];
         shift_ff <= dividend[cwm_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_ff   <= '0;
         div_ff   <= divisor;
      end else if (busy_ff) begin
         shift_ff <= shift_in;
         rem_ff   <= rem_in;
         if (step_ff == cwm_pkg::DIV_STEP_W'(cwm_pkg::SUM_W - 1)) begin
            quot_ff <= signed_q[cwm_pkg::VALUE_W-1:0];
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ===== rtl/clipped_window_mean.sv =====
// ============================================================================
// clipped_window_mean: box-filter mean over a grid with clipped borders
// Holds a grid of Q11.12 values and returns window means on query.
// ============================================================================
// A write word stores one cell and gives no response. A query clips its
// window to the grid, then reads the in-grid cells one per cycle from the
// single read port of the grid memory and divides the sum by the count in a
// bit-serial divider. One word is worked on at a time, and the next is
// accepted while a response still waits in the output register.
module clipped_window_mean (
   input  logic                                clock,
   input  logic                                reset,
   cwm_req_if.sink                             req_bus,
   cwm_rsp_if.source                           rsp_bus,
   input  logic                                csr_wr_en,
   input  logic [cwm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [cwm_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

   logic [cwm_pkg::VALUE_W-1:0]        grid_mem [cwm_pkg::GRID_DEPTH];

   state_type                          state_ff;
   state_type                          state_in;

   logic [cwm_pkg::SIZE_W-1:0]         rows_ff;
   logic [cwm_pkg::SIZE_W-1:0]         cols_ff;
   logic [cwm_pkg::HALF_W-1:0]         half_rows_ff;
   logic [cwm_pkg::HALF_W-1:0]         half_cols_ff;

   logic [cwm_pkg::POS_W-1:0]          r_lo_ff, r_hi_ff, c_hi_ff;
   logic [cwm_pkg::POS_W-1:0]          row_ff, col_ff;
   logic                               empty_ff;
   logic                               rd_vld_ff;
   logic signed [cwm_pkg::VALUE_W-1:0] rd_data_ff;
   logic signed [cwm_pkg::SUM_W-1:0]   sum_ff;
   logic [cwm_pkg::CNT_W-1:0]          cnt_ff;

   logic                               rsp_valid_ff;
   logic signed [cwm_pkg::VALUE_W-1:0] mean_ff;
   logic [cwm_pkg::CNT_W-1:0]          count_out_ff;
   logic                               empty_out_ff;

   logic                               accept;
   logic                               is_query;
   logic                               last_cell;
   logic                               div_done;
   logic signed [cwm_pkg::VALUE_W-1:0] div_quot;
   logic [cwm_pkg::ADDR_W-1:0]         wr_addr;
   logic [cwm_pkg::ADDR_W-1:0]         rd_addr;
   logic [cwm_pkg::SIZE_W-1:0]         n_rows, n_cols;
   logic signed [cwm_pkg::BND_W-1:0]   cr, cc, hr, hc, r_lim, c_lim;
   logic signed [cwm_pkg::BND_W-1:0]   r_lo_raw, r_hi_raw, c_lo_raw, c_hi_raw;
   logic signed [cwm_pkg::BND_W-1:0]   r_lo, r_hi, c_lo, c_hi;
   logic                               q_empty;
   logic                               out_free;

   assign accept   = req_bus.valid && req_bus.ready;
   assign is_query = (req_bus.req_type == cwm_pkg::REQ_QUERY);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   // Window bounds, clipped to the rows and columns in use.
   always_comb begin
      n_rows   = (rows_ff > cwm_pkg::SIZE_W'(cwm_pkg::MAX_ROWS))
                 ? cwm_pkg::SIZE_W'(cwm_pkg::MAX_ROWS) : rows_ff;
      n_cols   = (cols_ff > cwm_pkg::SIZE_W'(cwm_pkg::MAX_COLS))
                 ? cwm_pkg::SIZE_W'(cwm_pkg::MAX_COLS) : cols_ff;
      cr       = {{(cwm_pkg::BND_W-cwm_pkg::CENTER_W){req_bus.center_row[cwm_pkg::CENTER_W-1]}},
                  req_bus.center_row};
      cc       = {{(cwm_pkg::BND_W-cwm_pkg::CENTER_W){req_bus.center_col[cwm_pkg::CENTER_W-1]}},
                  req_bus.center_col};
      hr       = {{(cwm_pkg::BND_W-cwm_pkg::HALF_W){1'b0}}, half_rows_ff};
      hc       = {{(cwm_pkg::BND_W-cwm_pkg::HALF_W){1'b0}}, half_cols_ff};
      r_lim    = {{(cwm_pkg::BND_W-cwm_pkg::SIZE_W){1'b0}}, n_rows} - cwm_pkg::BND_W'(1);
      c_lim    = {{(cwm_pkg::BND_W-cwm_pkg::SIZE_W){1'b0}}, n_cols} - cwm_pkg::BND_W'(1);
      r_lo_raw = cr - hr;
      r_hi_raw = cr + hr;
      c_lo_raw = cc - hc;
      c_hi_raw = cc + hc;
      r_lo     = (r_lo_raw < 0) ? '0 : r_lo_raw;
      c_lo     = (c_lo_raw < 0) ? '0 : c_lo_raw;
      r_hi     = (r_hi_raw > r_lim) ? r_lim : r_hi_raw;
      c_hi     = (c_hi_raw > c_lim) ? c_lim : c_hi_raw;
      q_empty  = (r_lo > r_hi) || (c_lo > c_hi);
   end

   assign wr_addr   = cwm_pkg::ADDR_W'(req_bus.cell_row * cwm_pkg::MAX_COLS
                                       + req_bus.cell_col);
   assign rd_addr   = cwm_pkg::ADDR_W'(row_ff * cwm_pkg::MAX_COLS + col_ff);
   assign last_cell = (row_ff == r_hi_ff) && (col_ff == c_hi_ff);

   always_ff @(posedge clock) begin
      if (accept && !is_query
          && ({1'b0, req_bus.cell_row} < (cwm_pkg::POS_W+1)'(cwm_pkg::MAX_ROWS))
          && ({1'b0, req_bus.cell_col} < (cwm_pkg::POS_W+1)'(cwm_pkg::MAX_COLS))) begin
         grid_mem[wr_addr] <= req_bus.cell_value;
      end
      rd_data_ff <= grid_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= cwm_pkg::SIZE_W'(cwm_pkg::MAX_ROWS);
         cols_ff      <= cwm_pkg::SIZE_W'(cwm_pkg::MAX_COLS);
         half_rows_ff <= cwm_pkg::HALF_W'(1);
         half_cols_ff <= cwm_pkg::HALF_W'(1);
      end else if (csr_wr_en) begin
         unique case (cwm_pkg::csr_index_type'(csr_index))
            cwm_pkg::CSR_ROWS_IN_USE: rows_ff      <= csr_wdata[cwm_pkg::SIZE_W-1:0];
            cwm_pkg::CSR_COLS_IN_USE: cols_ff      <= csr_wdata[cwm_pkg::SIZE_W-1:0];
            cwm_pkg::CSR_HALF_ROWS:   half_rows_ff <= csr_wdata[cwm_pkg::HALF_W-1:0];
            cwm_pkg::CSR_HALF_COLS:   half_cols_ff <= csr_wdata[cwm_pkg::HALF_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && is_query) begin
               state_in = q_empty ? ST_DONE : ST_SCAN;
            end
         end
         ST_SCAN:  if (last_cell) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_DIV;
         ST_DIV:   state_in = ST_WAIT;
         ST_WAIT:  if (div_done) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff  <= state_in;
         rd_vld_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE && accept && is_query) begin
            sum_ff <= '0;
            cnt_ff <= '0;
         end else if (rd_vld_ff) begin
            sum_ff <= sum_ff + {{(cwm_pkg::SUM_W-cwm_pkg::VALUE_W){rd_data_ff[cwm_pkg::VALUE_W-1]}},
                                rd_data_ff};
            cnt_ff <= cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && accept && is_query) begin
         empty_ff <= q_empty;
         r_lo_ff  <= r_lo[cwm_pkg::POS_W-1:0];
         r_hi_ff  <= r_hi[cwm_pkg::POS_W-1:0];
         c_hi_ff  <= c_hi[cwm_pkg::POS_W-1:0];
         row_ff   <= r_lo[cwm_pkg::POS_W-1:0];
         col_ff   <= c_lo[cwm_pkg::POS_W-1:0];
      end else if (state_ff == ST_SCAN) begin
         if (row_ff == r_hi_ff) begin
            row_ff <= r_lo_ff;
            col_ff <= col_ff + 1'b1;
         end else begin
            row_ff <= row_ff + 1'b1;
         end
      end
      if (state_ff == ST_DONE && out_free) begin
         mean_ff      <= empty_ff ? '0 : div_quot;
         count_out_ff <= cnt_ff;
         empty_out_ff <= empty_ff;
      end
   end

   cwm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == ST_DIV),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign req_bus.ready         = (state_ff == ST_IDLE);
   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.mean_value    = mean_ff;
   assign rsp_bus.cells_counted = count_out_ff;
   assign rsp_bus.window_empty  = empty_out_ff;

endmodule

// ===== sim/tb_clipped_window_mean.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_clipped_window_mean: self-checking testbench for clipped_window_mean
// Loads grid cells and sends window queries through the request channel. A
// local model of the grid and the registers predicts each mean word, and the
// response process compares every field with the oldest prediction. The run
// covers border and fully outside windows, the size register limits, and
// random traffic over several register settings with random stalls.
// ============================================================================
module tb_clipped_window_mean;

   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int TAIL_CYCLES = 300;

   typedef struct {
      cwm_pkg::req_kind_type                kind;
      logic [cwm_pkg::POS_W-1:0]            row;
      logic [cwm_pkg::POS_W-1:0]            col;
      logic signed [cwm_pkg::VALUE_W-1:0]   value;
      logic signed [cwm_pkg::CENTER_W-1:0]  crow;
      logic signed [cwm_pkg::CENTER_W-1:0]  ccol;
   } grid_request_type;

   typedef struct {
      logic signed [cwm_pkg::VALUE_W-1:0]   mean;
      logic [cwm_pkg::CNT_W-1:0]            count;
      logic                                 empty;
   } window_result_type;

   logic                              clock;
   logic                              reset;
   logic                              csr_wr_en;
   logic [cwm_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [cwm_pkg::CSR_DATA_W-1:0]    csr_wdata;

   cwm_req_if req_bus ();
   cwm_rsp_if rsp_bus ();

   clipped_window_mean DUT (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic signed [cwm_pkg::VALUE_W-1:0] grid_copy [cwm_pkg::GRID_DEPTH];
   bit                                 cell_loaded [cwm_pkg::GRID_DEPTH];
   logic [cwm_pkg::SIZE_W-1:0]         cfg_rows;
   logic [cwm_pkg::SIZE_W-1:0]         cfg_cols;
   logic [cwm_pkg::HALF_W-1:0]         cfg_half_r;
   logic [cwm_pkg::HALF_W-1:0]         cfg_half_c;

   window_result_type pending_means [$];
   int                error_count = 0;
   int                words_sent;
   int unsigned       cycle_count = 0;
   bit                steady_flow;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      $display("mismatch at cycle %0d: %s", cycle_count, what);
   endtask

   function automatic window_result_type window_mean(input int crow, input int ccol);
      int                nr, nc, hr, hc, r, c, cnt;
      longint            sum;
      window_result_type res;
      nr = (cfg_rows > cwm_pkg::MAX_ROWS) ? cwm_pkg::MAX_ROWS : cfg_rows;
      nc = (cfg_cols > cwm_pkg::MAX_COLS) ? cwm_pkg::MAX_COLS : cfg_cols;
      hr = cfg_half_r;
      hc = cfg_half_c;
      sum = 0;
      cnt = 0;
      for (r = crow - hr; r <= crow + hr; r++) begin
         for (c = ccol - hc; c <= ccol + hc; c++) begin
            if (r >= 0 && r < nr && c >= 0 && c < nc) begin
               sum += grid_copy[r * cwm_pkg::MAX_COLS + c];
               cnt++;
            end
         end
      end
      res.count = cnt[cwm_pkg::CNT_W-1:0];
      res.empty = (cnt == 0);
      res.mean  = (cnt == 0) ? '0 : cwm_pkg::VALUE_W'(sum / cnt);
      return res;
   endfunction

   function automatic logic signed [cwm_pkg::VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0: return {1'b0, {(cwm_pkg::VALUE_W-1){1'b1}}};
         1: return {1'b1, {(cwm_pkg::VALUE_W-1){1'b0}}};
         2: return '0;
         default: return cwm_pkg::VALUE_W'($urandom);
      endcase
   endfunction

   // Sends one word and updates the model when it is accepted. Valid stays
   // high on return, so the caller either sends the next word or lowers it
   // in the same step.
   task automatic send_word(input grid_request_type w);
      if (!steady_flow) begin
         while ($urandom_range(99) < 33) begin
            req_bus.valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= w.kind;
      req_bus.cell_row   <= w.row;
      req_bus.cell_col   <= w.col;
      req_bus.cell_value <= w.value;
      req_bus.center_row <= w.crow;
      req_bus.center_col <= w.ccol;
      do @(posedge clock); while (!req_bus.ready);
      words_sent++;
      if (w.kind == cwm_pkg::REQ_WRITE) begin
         grid_copy[w.row * cwm_pkg::MAX_COLS + w.col]   = w.value;
         cell_loaded[w.row * cwm_pkg::MAX_COLS + w.col] = 1'b1;
      end else begin
         pending_means.insert(pending_means.size(), window_mean(w.crow, w.ccol));
      end
   endtask

   task automatic write_cell(input int row, input int col,
                             input logic signed [cwm_pkg::VALUE_W-1:0] value);
      grid_request_type w;
      w.kind  = cwm_pkg::REQ_WRITE;
      w.row   = row[cwm_pkg::POS_W-1:0];
      w.col   = col[cwm_pkg::POS_W-1:0];
      w.value = value;
      w.crow  = cwm_pkg::CENTER_W'($urandom);
      w.ccol  = cwm_pkg::CENTER_W'($urandom);
      send_word(w);
   endtask

   // Every in-grid cell of the window is loaded before the query goes out.
   task automatic query_window(input int crow, input int ccol);
      int               nr, nc, hr, hc, r, c;
      grid_request_type w;
      nr = (cfg_rows > cwm_pkg::MAX_ROWS) ? cwm_pkg::MAX_ROWS : cfg_rows;
      nc = (cfg_cols > cwm_pkg::MAX_COLS) ? cwm_pkg::MAX_COLS : cfg_cols;
      hr = cfg_half_r;
      hc = cfg_half_c;
      for (r = crow - hr; r <= crow + hr; r++) begin
         for (c = ccol - hc; c <= ccol + hc; c++) begin
            if (r >= 0 && r < nr && c >= 0 && c < nc
                && !cell_loaded[r * cwm_pkg::MAX_COLS + c]) begin
               write_cell(r, c, random_value());
            end
         end
      end
      w.kind  = cwm_pkg::REQ_QUERY;
      w.row   = cwm_pkg::POS_W'($urandom);
      w.col   = cwm_pkg::POS_W'($urandom);
      w.value = cwm_pkg::VALUE_W'($urandom);
      w.crow  = crow[cwm_pkg::CENTER_W-1:0];
      w.ccol  = ccol[cwm_pkg::CENTER_W-1:0];
      send_word(w);
   endtask

   // Lowers valid in the current step and waits until every mean word is back.
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input cwm_pkg::csr_index_type idx,
                            input logic [cwm_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         cwm_pkg::CSR_ROWS_IN_USE: cfg_rows   = data;
         cwm_pkg::CSR_COLS_IN_USE: cfg_cols   = data;
         cwm_pkg::CSR_HALF_ROWS:   cfg_half_r = data[cwm_pkg::HALF_W-1:0];
         cwm_pkg::CSR_HALF_COLS:   cfg_half_c = data[cwm_pkg::HALF_W-1:0];
      endcase
   endtask

   task automatic apply_setting(input int rows, input int cols, input int hr, input int hc);
      settle_block();
      write_csr(cwm_pkg::CSR_ROWS_IN_USE, rows[cwm_pkg::CSR_DATA_W-1:0]);
      write_csr(cwm_pkg::CSR_COLS_IN_USE, cols[cwm_pkg::CSR_DATA_W-1:0]);
      write_csr(cwm_pkg::CSR_HALF_ROWS, hr[cwm_pkg::CSR_DATA_W-1:0]);
      write_csr(cwm_pkg::CSR_HALF_COLS, hc[cwm_pkg::CSR_DATA_W-1:0]);
   endtask

   task automatic test_border_windows();
      write_cell(0, 0, 24'sh7FFFFF);
      write_cell(0, 1, 24'sh7FFFFF);
      write_cell(1, 0, 24'sh7FFFFF);
      write_cell(1, 1, 24'sh7FFFFF);
      query_window(0, 0);
      write_cell(63, 63, 24'sh800000);
      query_window(64, 64);
      query_window(63, 63);
      query_window(-1, -1);
      query_window(-2, 5);
      query_window(-128, -128);
      query_window(127, 127);
      query_window(127, -128);
      query_window(-64, 0);
      query_window(0, 63);
      query_window(32, 32);
   endtask

   task automatic test_size_registers();
      apply_setting(0, 64, 1, 1);
      query_window(0, 0);
      query_window(5, 5);
      apply_setting(100, 127, 1, 1);
      query_window(63, 63);
      query_window(64, 64);
      apply_setting(1, 1, 7, 7);
      query_window(0, 0);
      query_window(7, -7);
      query_window(8, 0);
      apply_setting(64, 64, 0, 0);
      query_window(32, 32);
      query_window(0, 63);
   endtask

   task automatic test_random_traffic();
      int rows_tab [10]   = '{64,  1, 20, 64, 64, 16, 64, 64, 100, 0};
      int cols_tab [10]   = '{64,  1, 20, 64, 64, 40, 64,  1,  64, 0};
      int hr_tab [10]     = '{ 1,  0,  7,  7,  0,  3,  2,  0,   1, 0};
      int hc_tab [10]     = '{ 1,  0,  7,  7,  0,  5,  2,  2,   3, 0};
      int lo_tab [10]     = '{-3, -2, -8, -8, -1, -6, -3, -3,  -4, -4};
      int hi_tab [10]     = '{66,  2, 27, 19, 64, 45, 40, 66,  67, 40};
      int share_tab [10]  = '{220, 80, 350, 200, 150, 150, 200, 100, 100, 100};
      int p, phase_end, mid, crow, ccol;
      bit paused;
      for (p = 0; p < 10; p++) begin
         if (p == 9) begin
            rows_tab[p] = $urandom_range(1, 64);
            cols_tab[p] = $urandom_range(1, 64);
            hr_tab[p]   = $urandom_range(0, 3);
            hc_tab[p]   = $urandom_range(0, 3);
         end
         apply_setting(rows_tab[p], cols_tab[p], hr_tab[p], hc_tab[p]);
         steady_flow = (p == 6);
         phase_end = words_sent + share_tab[p];
         mid = words_sent + share_tab[p] / 2;
         paused = 1'b0;
         while (words_sent < phase_end) begin
            if (!paused && words_sent >= mid) begin
               settle_block();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 20) begin
               write_cell($urandom_range(0, cwm_pkg::MAX_ROWS - 1),
                          $urandom_range(0, cwm_pkg::MAX_COLS - 1),
                          random_value());
            end else if ($urandom_range(99) < 20) begin
               query_window(int'($urandom_range(0, 255)) - 128,
                            int'($urandom_range(0, 255)) - 128);
            end else begin
               crow = lo_tab[p] + int'($urandom_range(0, hi_tab[p] - lo_tab[p]));
               ccol = lo_tab[p] + int'($urandom_range(0, hi_tab[p] - lo_tab[p]));
               query_window(crow, ccol);
            end
         end
         steady_flow = 1'b0;
      end
   endtask

   always @(posedge clock) begin : check_responses
      window_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady_flow || ($urandom_range(99) >= 33);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_means.size() == 0) begin
               report_mismatch("mean word arrived with none expected");
            end else begin
               want = pending_means.pop_front();
               if (rsp_bus.mean_value !== want.mean)
                  report_mismatch($sformatf("mean_value %0d, expected %0d",
                                            rsp_bus.mean_value, want.mean));
               if (rsp_bus.cells_counted !== want.count)
                  report_mismatch($sformatf("cells_counted %0d, expected %0d",
                                            rsp_bus.cells_counted, want.count));
               if (rsp_bus.window_empty !== want.empty)
                  report_mismatch($sformatf("window_empty %0b, expected %0b",
                                            rsp_bus.window_empty, want.empty));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[clipped_window_mean] ERROR");
         $finish;
      end
   end

   initial begin
      words_sent  = 0;
      steady_flow = 1'b0;
      cfg_rows    = 7'd64;
      cfg_cols    = 7'd64;
      cfg_half_r  = 3'd1;
      cfg_half_c  = 3'd1;
      reset              <= 1'b1;
      csr_wr_en          <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= cwm_pkg::REQ_WRITE;
      req_bus.cell_row   <= '0;
      req_bus.cell_col   <= '0;
      req_bus.cell_value <= '0;
      req_bus.center_row <= '0;
      req_bus.center_col <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_border_windows();
      test_size_registers();
      test_random_traffic();

      settle_block();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("[clipped_window_mean] OK");
      end else begin
         $display("[clipped_window_mean] ERROR");
      end
      $finish;
   end

endmodule
